// ===== hw/rtl/arcball_map_to_sphere_core_assert.svh =====
// assertion helpers shared by the arcball core
`ifndef ARCBALL_MAP_TO_SPHERE_CORE_ASSERT_SVH
`define ARCBALL_MAP_TO_SPHERE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AMS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define AMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ams_pkg.sv =====
`timescale 1ns / 1ps

package ams_pkg;

   // field widths and defaults
   localparam int SCALE_BITS     = 18;
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 15;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(128);

   // configuration register indexes
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_X_SCALE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_Y_SCALE = 2'd1;

   // square root chain: one root bit per cell
   localparam int ROOT_BITS   = 32;
   localparam int RAD_BITS    = 2 * ROOT_BITS;
   localparam int SQ_REM_BITS = ROOT_BITS + 2;

   // divider chain: denominator is twice the root
   localparam int DEN_BITS = ROOT_BITS + 1;

   // the larger normalized magnitude lies in [2^29, 2^30)
   localparam int NORM_BITS = 30;
   localparam int NORM_MSB  = 29;

endpackage

// ===== hw/rtl/ams_sqrt_cell.sv =====
`timescale 1ns / 1ps

module ams_sqrt_cell (
   input  logic                              clock,
   input  logic [ams_pkg::SQ_REM_BITS-1:0]   rem_i,
   input  logic [ams_pkg::ROOT_BITS-1:0]     root_i,
   input  logic [ams_pkg::RAD_BITS-1:0]      rad_i,
   output logic [ams_pkg::SQ_REM_BITS-1:0]   rem_o,
   output logic [ams_pkg::ROOT_BITS-1:0]     root_o,
   output logic [ams_pkg::RAD_BITS-1:0]      rad_o
);

   logic [ams_pkg::SQ_REM_BITS-1:0] cur;
   logic [ams_pkg::SQ_REM_BITS-1:0] trial;
   logic [ams_pkg::SQ_REM_BITS-1:0] rem_in, rem_ff;
   logic [ams_pkg::ROOT_BITS-1:0]   root_in, root_ff;
   logic [ams_pkg::RAD_BITS-1:0]    rad_in, rad_ff;

   // bring down the next two radicand bits and try the next root bit
   always_comb begin
      cur   = {rem_i[ams_pkg::SQ_REM_BITS-3:0], rad_i[ams_pkg::RAD_BITS-1 -: 2]};
      trial = {root_i, 2'b01};
      if (cur >= trial) begin
         rem_in  = cur - trial;
         root_in = {root_i[ams_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
         rem_in  = cur;
         root_in = {root_i[ams_pkg::ROOT_BITS-2:0], 1'b0};
      end
      rad_in = {rad_i[ams_pkg::RAD_BITS-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign rad_o  = rad_ff;

endmodule

// ===== hw/rtl/ams_div_cell.sv =====
`timescale 1ns / 1ps

module ams_div_cell #(
   parameter int QW = ams_pkg::FRAC_BITS_DEF + 1
) (
   input  logic                           clock,
   input  logic [ams_pkg::DEN_BITS-1:0]   den_i,
   input  logic [ams_pkg::DEN_BITS-1:0]   rem_x_i,
   input  logic [ams_pkg::DEN_BITS-1:0]   rem_y_i,
   input  logic [QW-1:0]                  low_x_i,
   input  logic [QW-1:0]                  low_y_i,
   input  logic [QW-1:0]                  quo_x_i,
   input  logic [QW-1:0]                  quo_y_i,
   output logic [ams_pkg::DEN_BITS-1:0]   den_o,
   output logic [ams_pkg::DEN_BITS-1:0]   rem_x_o,
   output logic [ams_pkg::DEN_BITS-1:0]   rem_y_o,
   output logic [QW-1:0]                  low_x_o,
   output logic [QW-1:0]                  low_y_o,
   output logic [QW-1:0]                  quo_x_o,
   output logic [QW-1:0]                  quo_y_o
);

   localparam int CW = ams_pkg::DEN_BITS + 1;

   logic [CW-1:0] cur_x, cur_y;
   logic          qx, qy;
   logic [ams_pkg::DEN_BITS-1:0] den_ff, rem_x_in, rem_x_ff, rem_y_in, rem_y_ff;
   logic [QW-1:0] low_x_ff, low_y_ff, quo_x_ff, quo_y_ff;

   // restoring step on both lanes, sharing the denominator
   always_comb begin
      cur_x = {rem_x_i, low_x_i[QW-1]};
      cur_y = {rem_y_i, low_y_i[QW-1]};
      qx    = (cur_x >= {1'b0, den_i});
      qy    = (cur_y >= {1'b0, den_i});
      rem_x_in = qx ? ams_pkg::DEN_BITS'(cur_x - {1'b0, den_i})
                    : ams_pkg::DEN_BITS'(cur_x);
      rem_y_in = qy ? ams_pkg::DEN_BITS'(cur_y - {1'b0, den_i})
                    : ams_pkg::DEN_BITS'(cur_y);
   end

   always_ff @(posedge clock) begin
      den_ff   <= den_i;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      low_x_ff <= {low_x_i[QW-2:0], 1'b0};
      low_y_ff <= {low_y_i[QW-2:0], 1'b0};
      quo_x_ff <= {quo_x_i[QW-2:0], qx};
      quo_y_ff <= {quo_y_i[QW-2:0], qy};
   end

   assign den_o   = den_ff;
   assign rem_x_o = rem_x_ff;
   assign rem_y_o = rem_y_ff;
   assign low_x_o = low_x_ff;
   assign low_y_o = low_y_ff;
   assign quo_x_o = quo_x_ff;
   assign quo_y_o = quo_y_ff;

endmodule

// ===== hw/rtl/arcball_map_to_sphere_core.sv =====
`timescale 1ns / 1ps

// Arcball mapping core: pointer position in pixels to a point on the unit sphere.
// Input: raise start with req_point_x / req_point_y; the word is taken at a
// clock edge where start is high and busy is low. busy is low except just after
// reset, so a new point may be given every cycle.
// Output: rsp_valid pulses for one cycle with rsp_sphere_x/y/z and
// rsp_outside_ball. There is no back pressure; the receiver must take every word.
// Throughput: one point per clock.
// The latency is set by a chain of 32 square root cells (one root bit each)
// followed by FRAC_BITS+1 divider cells (one quotient bit each) that normalize
// points outside the ball; six front stages do scaling, squares, normalizing
// and radicand select, one stage prepares the divide and one encodes the result.
// Config: csr_valid/csr_ready/csr_index/csr_data write x_scale (index 0) and
// y_scale (index 1); other indexes are ignored. csr_ready is always high.
// Reset: synchronous; both scales return to 128, all words in flight are dropped.
module arcball_map_to_sphere_core #(
   parameter int COORD_BITS = ams_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = ams_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [COORD_BITS-1:0]                req_point_x,
   input  logic [COORD_BITS-1:0]                req_point_y,
   output logic                                 rsp_valid,
   output logic signed [FRAC_BITS:0]            rsp_sphere_x,
   output logic signed [FRAC_BITS:0]            rsp_sphere_y,
   output logic [FRAC_BITS-1:0]                 rsp_sphere_z,
   output logic                                 rsp_outside_ball,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ams_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [ams_pkg::SCALE_BITS-1:0]       csr_data
);

   `include "arcball_map_to_sphere_core_assert.svh"

   localparam int F      = FRAC_BITS;
   localparam int QW     = F + 1;
   localparam int PW     = COORD_BITS + ams_pkg::SCALE_BITS;
   localparam int MW     = $clog2(PW);
   localparam int NB     = ams_pkg::NORM_BITS;
   localparam int RB     = ams_pkg::ROOT_BITS;
   localparam int DB     = ams_pkg::DEN_BITS;
   localparam int NCELL  = ams_pkg::ROOT_BITS;
   localparam int MQ     = F + 18;
   localparam int QSH_L  = (F >= 16) ? F - 16 : 0;
   localparam int QSH_R  = (F < 16) ? 16 - F : 0;
   localparam int RND    = (F < 16) ? (1 << ((F < 16) ? 15 - F : 0)) : 0;
   localparam int K      = 2 * F - 30;
   localparam int KL     = (K > 0) ? K : 0;
   localparam int KR     = (K < 0) ? -K : 0;
   localparam int V_SQ0  = 6;
   localparam int V_PREP = V_SQ0 + NCELL;
   localparam int V_DIV0 = V_PREP + 1;
   localparam int V_OUT  = V_DIV0 + QW;
   localparam int LAT    = V_OUT + 1;

   typedef struct packed {
      logic          nx;
      logic          ny;
      logic          outside;
      logic [F:0]    in_x;
      logic [F:0]    in_y;
      logic [NB-1:0] mxn;
      logic [NB-1:0] myn;
      logic [F-1:0]  z;
   } side_type;

   // saturating sign encode into Q1.F
   function automatic logic [F:0] enc(input logic [F:0] mag, input logic neg);
      logic [F:0] one_c;
      logic [F:0] lim;
      one_c = (F+1)'(1) << F;
      if (neg) begin
         lim = (mag > one_c) ? one_c : mag;
         enc = (F+1)'(0) - lim;
      end else begin
         lim = (mag > one_c - (F+1)'(1)) ? one_c - (F+1)'(1) : mag;
         enc = lim;
      end
   endfunction

   logic accept;
   logic busy_ff;
   logic [LAT-1:0] vld_ff;
   logic [ams_pkg::SCALE_BITS-1:0] x_scale_ff, y_scale_ff;

   assign accept    = start & ~busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   // control: busy only right after reset, valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= {vld_ff[LAT-2:0], accept};
      end
   end

   // scale registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff <= ams_pkg::SCALE_RESET;
         y_scale_ff <= ams_pkg::SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ams_pkg::CSR_X_SCALE: x_scale_ff <= csr_data;
            ams_pkg::CSR_Y_SCALE: y_scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: pixel times scale
   logic [PW-1:0] p1_ff, q1_ff;
   always_ff @(posedge clock) begin
      p1_ff <= PW'(req_point_x) * PW'(x_scale_ff);
      q1_ff <= PW'(req_point_y) * PW'(y_scale_ff);
   end

   // stage 2: sign and magnitude of x = p - 1, y = 1 - q
   localparam logic [PW-1:0] ONE_P = PW'(1) << 16;
   logic [PW-1:0] mx2_in, my2_in, mx2_ff, my2_ff;
   logic nx2_in, ny2_in, nx2_ff, ny2_ff, ovf2_ff;
   always_comb begin
      nx2_in = p1_ff < ONE_P;
      mx2_in = nx2_in ? ONE_P - p1_ff : p1_ff - ONE_P;
      ny2_in = q1_ff > ONE_P;
      my2_in = ny2_in ? q1_ff - ONE_P : ONE_P - q1_ff;
   end
   always_ff @(posedge clock) begin
      mx2_ff  <= mx2_in;
      my2_ff  <= my2_in;
      nx2_ff  <= nx2_in;
      ny2_ff  <= ny2_in;
      ovf2_ff <= (mx2_in > ONE_P) || (my2_in > ONE_P);
   end

   // stage 3: squares, leading one of the larger magnitude, inside codes
   logic [33:0] sqx3_ff, sqy3_ff;
   logic [MW-1:0] m3_in, m3_ff;
   logic [PW-1:0] mx3_ff, my3_ff, orv;
   logic [MQ-1:0] qx_t, qy_t;
   side_type side3_in, side3_ff;
   always_comb begin
      orv   = mx2_ff | my2_ff;
      m3_in = '0;
      for (int i = 0; i < PW; i++) begin
         if (orv[i]) m3_in = MW'(i);
      end
      qx_t = ((MQ'(mx2_ff[16:0]) << QSH_L) + MQ'(RND)) >> QSH_R;
      qy_t = ((MQ'(my2_ff[16:0]) << QSH_L) + MQ'(RND)) >> QSH_R;
      side3_in         = '0;
      side3_in.nx      = nx2_ff;
      side3_in.ny      = ny2_ff;
      side3_in.outside = ovf2_ff;
      side3_in.in_x    = enc(qx_t[F:0], nx2_ff);
      side3_in.in_y    = enc(qy_t[F:0], ny2_ff);
   end
   always_ff @(posedge clock) begin
      sqx3_ff  <= mx2_ff[16:0] * mx2_ff[16:0];
      sqy3_ff  <= my2_ff[16:0] * my2_ff[16:0];
      m3_ff    <= m3_in;
      mx3_ff   <= mx2_ff;
      my3_ff   <= my2_ff;
      side3_ff <= side3_in;
   end

   // stage 4: r and the ball test, normalizing shift, 1 - r
   logic [34:0] r4;
   logic [32:0] d4_ff;
   side_type side4_in, side4_ff;
   always_comb begin
      r4       = 35'(sqx3_ff) + 35'(sqy3_ff);
      side4_in = side3_ff;
      side4_in.outside = side3_ff.outside || (r4 > (35'(1) << 32));
      if (int'(m3_ff) > ams_pkg::NORM_MSB) begin
         side4_in.mxn = NB'(mx3_ff >> (int'(m3_ff) - ams_pkg::NORM_MSB));
         side4_in.myn = NB'(my3_ff >> (int'(m3_ff) - ams_pkg::NORM_MSB));
      end else begin
         side4_in.mxn = NB'(mx3_ff << (ams_pkg::NORM_MSB - int'(m3_ff)));
         side4_in.myn = NB'(my3_ff << (ams_pkg::NORM_MSB - int'(m3_ff)));
      end
   end
   always_ff @(posedge clock) begin
      d4_ff    <= 33'((35'(1) << 32) - r4);
      side4_ff <= side4_in;
   end

   // stage 5: squares of the normalized magnitudes
   logic [2*NB-1:0] sqx5_ff, sqy5_ff;
   logic [32:0] d5_ff;
   side_type side5_ff;
   always_ff @(posedge clock) begin
      sqx5_ff  <= side4_ff.mxn * side4_ff.mxn;
      sqy5_ff  <= side4_ff.myn * side4_ff.myn;
      d5_ff    <= d4_ff;
      side5_ff <= side4_ff;
   end

   // stage 6: pick the radicand for the root chain
   logic [ams_pkg::RAD_BITS-1:0] rad6_ff;
   side_type side6_ff;
   always_ff @(posedge clock) begin
      if (side5_ff.outside) begin
         rad6_ff <= ams_pkg::RAD_BITS'(sqx5_ff) + ams_pkg::RAD_BITS'(sqy5_ff);
      end else begin
         rad6_ff <= (ams_pkg::RAD_BITS'(d5_ff) << KL) >> KR;
      end
      side6_ff <= side5_ff;
   end

   // square root chain
   logic [ams_pkg::SQ_REM_BITS-1:0] sq_rem  [0:NCELL];
   logic [RB-1:0]                   sq_root [0:NCELL];
   logic [ams_pkg::RAD_BITS-1:0]    sq_rad  [0:NCELL];
   side_type                        sq_side_ff [0:NCELL-1];

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = rad6_ff;

   for (genvar i = 0; i < NCELL; i++) begin : g_sq
      ams_sqrt_cell u_cell (
         .clock  (clock),
         .rem_i  (sq_rem[i]),
         .root_i (sq_root[i]),
         .rad_i  (sq_rad[i]),
         .rem_o  (sq_rem[i+1]),
         .root_o (sq_root[i+1]),
         .rad_o  (sq_rad[i+1])
      );
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            sq_side_ff[i] <= side6_ff;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            sq_side_ff[i] <= sq_side_ff[i-1];
         end
      end
   end

   // divide set-up: den = 2s, numerator = mag * 2^(F+1) + s
   logic [RB-1:0] s_root;
   logic [RB:0]   z_wide;
   logic [DB-1:0] den_ff, remx_ff, remy_ff;
   logic [QW-1:0] lowx_ff, lowy_ff;
   side_type side_p_in, side_p_ff;
   localparam logic [RB:0] ZMAX = (RB+1)'((64'(1) << F) - 64'(1));
   always_comb begin
      s_root    = sq_root[NCELL];
      z_wide    = ((RB+1)'(s_root) + (RB+1)'(1)) >> 1;
      side_p_in = sq_side_ff[NCELL-1];
      side_p_in.z = (z_wide > ZMAX) ? F'(ZMAX) : F'(z_wide);
   end
   always_ff @(posedge clock) begin
      den_ff    <= {s_root, 1'b0};
      remx_ff   <= DB'(sq_side_ff[NCELL-1].mxn) + DB'(s_root >> QW);
      remy_ff   <= DB'(sq_side_ff[NCELL-1].myn) + DB'(s_root >> QW);
      lowx_ff   <= s_root[QW-1:0];
      lowy_ff   <= s_root[QW-1:0];
      side_p_ff <= side_p_in;
   end

   // divider chain
   logic [DB-1:0] dv_den   [0:QW];
   logic [DB-1:0] dv_rem_x [0:QW];
   logic [DB-1:0] dv_rem_y [0:QW];
   logic [QW-1:0] dv_low_x [0:QW];
   logic [QW-1:0] dv_low_y [0:QW];
   logic [QW-1:0] dv_quo_x [0:QW];
   logic [QW-1:0] dv_quo_y [0:QW];
   side_type      dv_side_ff [0:QW-1];

   assign dv_den[0]   = den_ff;
   assign dv_rem_x[0] = remx_ff;
   assign dv_rem_y[0] = remy_ff;
   assign dv_low_x[0] = lowx_ff;
   assign dv_low_y[0] = lowy_ff;
   assign dv_quo_x[0] = '0;
   assign dv_quo_y[0] = '0;

   for (genvar j = 0; j < QW; j++) begin : g_dv
      ams_div_cell #(.QW(QW)) u_cell (
         .clock   (clock),
         .den_i   (dv_den[j]),
         .rem_x_i (dv_rem_x[j]),
         .rem_y_i (dv_rem_y[j]),
         .low_x_i (dv_low_x[j]),
         .low_y_i (dv_low_y[j]),
         .quo_x_i (dv_quo_x[j]),
         .quo_y_i (dv_quo_y[j]),
         .den_o   (dv_den[j+1]),
         .rem_x_o (dv_rem_x[j+1]),
         .rem_y_o (dv_rem_y[j+1]),
         .low_x_o (dv_low_x[j+1]),
         .low_y_o (dv_low_y[j+1]),
         .quo_x_o (dv_quo_x[j+1]),
         .quo_y_o (dv_quo_y[j+1])
      );
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            dv_side_ff[j] <= side_p_ff;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            dv_side_ff[j] <= dv_side_ff[j-1];
         end
      end
   end

   // output register
   side_type      side_o;
   logic [F:0]    out_x_ff, out_y_ff;
   logic [F-1:0]  out_z_ff;
   logic          out_o_ff;
   assign side_o = dv_side_ff[QW-1];
   always_ff @(posedge clock) begin
      if (side_o.outside) begin
         out_x_ff <= enc(dv_quo_x[QW], side_o.nx);
         out_y_ff <= enc(dv_quo_y[QW], side_o.ny);
         out_z_ff <= '0;
         out_o_ff <= 1'b1;
      end else begin
         out_x_ff <= side_o.in_x;
         out_y_ff <= side_o.in_y;
         out_z_ff <= side_o.z;
         out_o_ff <= 1'b0;
      end
   end

   assign rsp_valid        = vld_ff[V_OUT];
   assign rsp_sphere_x     = $signed(out_x_ff);
   assign rsp_sphere_y     = $signed(out_y_ff);
   assign rsp_sphere_z     = out_z_ff;
   assign rsp_outside_ball = out_o_ff;

   // checks
   `AMS_ASSERT_IMPL(a_den_nonzero, clock, reset,
      vld_ff[V_PREP] && side_p_ff.outside, den_ff != '0,
      "outside point reached the divider with a zero root")
   `AMS_ASSERT_IMPL(a_quo_fits, clock, reset,
      vld_ff[V_PREP] && side_p_ff.outside, (remx_ff < den_ff) && (remy_ff < den_ff),
      "divider start remainder not below denominator")
   `AMS_ASSERT_NEXT(a_outside_z, clock, reset,
      vld_ff[V_OUT-1] && side_o.outside, rsp_valid && rsp_outside_ball && rsp_sphere_z == '0,
      "outside result lost its flag or has nonzero z")

endmodule
